@@ sv/masked_anisotropic_laplacian_stencil_macros.svh @@
// Assertion macros used by the stencil top level.
`ifndef MASKED_ANISOTROPIC_LAPLACIAN_STENCIL_MACROS_SVH
`define MASKED_ANISOTROPIC_LAPLACIAN_STENCIL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MALS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MALS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/mals_pkg.sv @@
// Shared types and constants of the masked Laplacian stencil.
package mals_pkg;

	// Field widths
	localparam int SAMPLE_W   = 24;
	localparam int BATHY_W    = 12;
	localparam int PLANE_W    = 12;
	localparam int SIZE_W     = 8;
	localparam int DEPTH_W    = 13;
	localparam int GAIN_W     = 24;
	localparam int HV_W       = 32;
	localparam int IN_TDATA_W = 40;
	localparam int APB_AW     = 4;
	localparam int APB_DW     = 32;

	// Size limits and the vertical weight 0.03 in Q0.16
	localparam int MIN_SIZE  = 3;
	localparam int MAX_DEPTH = 4096;
	localparam int CV_Q16    = 1966;

	// Register indexes
	localparam logic [1:0] REG_SIZE_FAST   = 2'd0;
	localparam logic [1:0] REG_SIZE_MIDDLE = 2'd1;
	localparam logic [1:0] REG_SIZE_DEPTH  = 2'd2;
	localparam logic [1:0] REG_GAIN        = 2'd3;

	// Neighbor read order; the vertical tap is the last one
	typedef logic [2:0] tap_idx_t;
	localparam tap_idx_t TAP_CENTER  = 3'd0;
	localparam tap_idx_t TAP_FAST_LO = 3'd1;
	localparam tap_idx_t TAP_FAST_HI = 3'd2;
	localparam tap_idx_t TAP_MID_LO  = 3'd3;
	localparam tap_idx_t TAP_MID_HI  = 3'd4;
	localparam tap_idx_t TAP_VERT    = 3'd5;
	localparam int NUM_HTAPS = 5;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_CALC,
		ST_FINISH
	} state_t;

	// Request to the arithmetic pipeline
	typedef struct packed {
		logic                       start;
		logic signed [SAMPLE_W-1:0] center;
		logic signed [SAMPLE_W-1:0] fast_lo;
		logic signed [SAMPLE_W-1:0] fast_hi;
		logic signed [SAMPLE_W-1:0] mid_lo;
		logic signed [SAMPLE_W-1:0] mid_hi;
		logic signed [SAMPLE_W-1:0] vert;
		logic signed [SAMPLE_W-1:0] cur;
	} calc_req_t;

	// Response of the arithmetic pipeline
	typedef struct packed {
		logic                   done;
		logic signed [HV_W-1:0] hv;
	} calc_rsp_t;

endpackage

@@ sv/mals_calc.sv @@
// Five-stage arithmetic pipeline: second differences, weighting, rounding, gain, rounding with saturation.
module mals_calc
	import mals_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  calc_req_t         req,
	input  logic [GAIN_W-1:0] gain,
	output calc_rsp_t         rsp
);

	localparam int D_W   = SAMPLE_W + 2;
	localparam int DS_W  = SAMPLE_W + 3;
	localparam int VP_W  = D_W + 12;
	localparam int S16_W = SAMPLE_W + 4;
	localparam int P_W   = S16_W + GAIN_W + 1;
	localparam int R_W   = P_W - 16;
	localparam logic signed [VP_W-1:0] CV_S      = VP_W'(CV_Q16);
	localparam logic signed [VP_W-1:0] HALF_V    = VP_W'(32768);
	localparam logic signed [P_W-1:0]  HALF_P    = P_W'(32768);
	localparam logic signed [HV_W-1:0] HV_MAX    = {1'b0, {(HV_W-1){1'b1}}};
	localparam logic signed [HV_W-1:0] HV_MIN    = {1'b1, {(HV_W-1){1'b0}}};

	logic                    v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [DS_W-1:0]  dsum_s1, dsum_s2;
	logic signed [D_W-1:0]   dv_s1;
	logic signed [VP_W-1:0]  vprod_s2;
	logic signed [S16_W-1:0] s16_s3;
	logic signed [P_W-1:0]   p_s4;
	logic signed [HV_W-1:0]  hv_s5;
	logic signed [D_W-1:0]   d_fast, d_mid, d_vert;
	logic signed [VP_W-1:0]  vround;
	logic signed [P_W-1:0]   pround;
	logic signed [R_W-1:0]   r_full;
	logic                    r_ovf;
	logic signed [HV_W-1:0]  hv_sat;

	// Exact second difference 2*b - a - c.
	function automatic logic signed [D_W-1:0] second_diff(
		input logic signed [SAMPLE_W-1:0] b,
		input logic signed [SAMPLE_W-1:0] a,
		input logic signed [SAMPLE_W-1:0] c
	);
		second_diff = (D_W'(b) <<< 1) - D_W'(a) - D_W'(c);
	endfunction

	// Stage one operands.
	always_comb begin
		d_fast = second_diff(req.center, req.fast_lo, req.fast_hi);
		d_mid  = second_diff(req.center, req.mid_lo, req.mid_hi);
		d_vert = second_diff(req.center, req.vert, req.cur);
	end

	// Rounding of the vertical term and of the gained product, with saturation.
	always_comb begin
		vround = vprod_s2 + HALF_V;
		pround = p_s4 + HALF_P;
		r_full = pround[P_W-1:16];
		r_ovf  = !((&r_full[R_W-1:HV_W-1]) || (~|r_full[R_W-1:HV_W-1]));
		if (r_ovf) begin
			hv_sat = r_full[R_W-1] ? HV_MIN : HV_MAX;
		end else begin
			hv_sat = r_full[HV_W-1:0];
		end
	end

	// Valid bits of the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= req.start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stage payloads. The horizontal weight is one, so the Q.16 horizontal sum
	// has zero low bits and only the vertical term needs rounding.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dsum_s1 <= DS_W'(d_fast) + DS_W'(d_mid);
			dv_s1   <= d_vert;
		end
		if (v_s1) begin
			dsum_s2  <= dsum_s1;
			vprod_s2 <= VP_W'(dv_s1) * CV_S;
		end
		if (v_s2) begin
			s16_s3 <= S16_W'(dsum_s2) + S16_W'($signed(vround[VP_W-1:16]));
		end
		if (v_s3) begin
			p_s4 <= P_W'(s16_s3) * P_W'($signed({1'b0, gain}));
		end
		if (v_s4) begin
			hv_s5 <= hv_sat;
		end
	end

	assign rsp.done = v_s5;
	assign rsp.hv   = hv_s5;

endmodule

@@ sv/masked_anisotropic_laplacian_stencil.sv @@
// Masked anisotropic seven-point Laplacian stencil: top level.
//
// A volume streams in on s_axis one voxel per beat in raster order, fast axis
// first, then middle axis, then planes. Each beat carries the voxel sample and
// the bathymetry plane index of its column. For every voxel of plane p >= 1 a
// result beat on m_axis gives the regularization increment of the voxel at the
// same column of plane p-1; tlast marks the final result of the volume.
// Boundary voxels and voxels at or above the bathymetry depth give zero.
// Sizes and gain are to be written over the APB port only while the block is
// idle; the block itself does not enforce this. Two planes of samples live in
// one single-port-read ring memory. An interior voxel goes through the accept,
// six ring reads (one per cycle on the single read port), the registered read,
// five arithmetic stages and the write-back. Any other voxel goes from the
// accept straight to the write-back. The result appears on m_axis in the cycle
// after the write-back. A result that waits in the output register does not
// stop the next voxel from being accepted; only the write-back of a further
// result waits for the receiver to take it. Reset clears the positions and the
// registers (sizes 128, 128, 4096, gain 0); the ring needs no clearing.
`include "masked_anisotropic_laplacian_stencil_macros.svh"

module masked_anisotropic_laplacian_stencil
	import mals_pkg::*;
#(
	parameter int MAX_FAST   = 128,
	parameter int MAX_MIDDLE = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// APB configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_AW-1:0]     paddr,
	input  logic [APB_DW-1:0]     pwdata,
	output logic [APB_DW-1:0]     prdata,
	output logic                  pready,
	// Voxel input
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_TDATA_W-1:0] s_axis_tdata,   // [23:0] sample, [35:24] bathy_depth
	// Increment output
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [HV_W-1:0]       m_axis_tdata,   // [31:0] hv_increment
	output logic                  m_axis_tlast
);

	localparam int FW          = $clog2(MAX_FAST);
	localparam int MW          = $clog2(MAX_MIDDLE);
	localparam int PLANE_WORDS = MAX_FAST * MAX_MIDDLE;
	localparam int RING_DEPTH  = 2 * PLANE_WORDS;
	localparam int AW          = $clog2(RING_DEPTH);

	// Configuration registers
	logic [SIZE_W-1:0]  size_fast_q, size_middle_q;
	logic [DEPTH_W-1:0] size_depth_q;
	logic [GAIN_W-1:0]  gain_q;
	logic               cfg_wr;

	// Effective sizes
	logic [FW:0]        nf;
	logic [MW:0]        nm;
	logic [DEPTH_W-1:0] nd;

	// Positions and per-voxel decode
	logic [FW-1:0]      fast_pos_q;
	logic [MW-1:0]      mid_pos_q;
	logic [PLANE_W-1:0] plane_pos_q;
	logic [PLANE_W-1:0] prev_plane;
	logic [BATHY_W-1:0] in_bathy;
	logic               wrap_f, wrap_m, wrap_p, in_emit, in_interior, in_accept;

	// Latched voxel
	logic signed [SAMPLE_W-1:0] cur_q;
	logic [FW-1:0]              item_fast_q;
	logic [MW-1:0]              item_mid_q;
	logic                       item_bank_q;
	logic                       emit_q, interior_q, last_q;

	// Sequencer
	state_t   state_q, state_d;
	tap_idx_t rd_cnt_q;
	logic     ring_re, ring_we, calc_start, out_load;

	// Ring memory
	logic [SAMPLE_W-1:0]        ring_q [RING_DEPTH];
	logic [SAMPLE_W-1:0]        ring_rdata_q;
	logic [AW-1:0]              ring_raddr, ring_waddr;
	logic                       rd_bank;
	logic [MW-1:0]              rd_mid;
	logic [FW-1:0]              rd_fast;
	logic                       rd_vld_s1;
	tap_idx_t                   rd_idx_s1;
	logic signed [SAMPLE_W-1:0] tap_q [NUM_HTAPS];

	// Arithmetic and output
	calc_req_t              calc_req;
	calc_rsp_t              calc_rsp;
	logic                   out_vld_q, out_last_q;
	logic signed [HV_W-1:0] out_hv_q;

	// Linear ring address of a column in one of the two plane banks.
	function automatic logic [AW-1:0] ring_addr(
		input logic          bank,
		input logic [MW-1:0] row,
		input logic [FW-1:0] col
	);
		ring_addr = (bank ? AW'(PLANE_WORDS) : AW'(0)) + AW'(row) * AW'(MAX_FAST) + AW'(col);
	endfunction

	// APB register file.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_fast_q   <= SIZE_W'(128);
			size_middle_q <= SIZE_W'(128);
			size_depth_q  <= DEPTH_W'(MAX_DEPTH);
			gain_q        <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_SIZE_FAST:   size_fast_q   <= pwdata[SIZE_W-1:0];
				REG_SIZE_MIDDLE: size_middle_q <= pwdata[SIZE_W-1:0];
				REG_SIZE_DEPTH:  size_depth_q  <= pwdata[DEPTH_W-1:0];
				REG_GAIN:        gain_q        <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_SIZE_FAST:   prdata = APB_DW'(size_fast_q);
			REG_SIZE_MIDDLE: prdata = APB_DW'(size_middle_q);
			REG_SIZE_DEPTH:  prdata = APB_DW'(size_depth_q);
			REG_GAIN:        prdata = APB_DW'(gain_q);
			default:         prdata = '0;
		endcase
	end

	// Sizes clamped to their legal ranges.
	always_comb begin
		if (size_fast_q < SIZE_W'(MIN_SIZE)) begin
			nf = (FW+1)'(MIN_SIZE);
		end else if (32'(size_fast_q) > 32'(MAX_FAST)) begin
			nf = (FW+1)'(MAX_FAST);
		end else begin
			nf = (FW+1)'(size_fast_q);
		end
		if (size_middle_q < SIZE_W'(MIN_SIZE)) begin
			nm = (MW+1)'(MIN_SIZE);
		end else if (32'(size_middle_q) > 32'(MAX_MIDDLE)) begin
			nm = (MW+1)'(MAX_MIDDLE);
		end else begin
			nm = (MW+1)'(size_middle_q);
		end
		if (size_depth_q < DEPTH_W'(MIN_SIZE)) begin
			nd = DEPTH_W'(MIN_SIZE);
		end else if (size_depth_q > DEPTH_W'(MAX_DEPTH)) begin
			nd = DEPTH_W'(MAX_DEPTH);
		end else begin
			nd = size_depth_q;
		end
	end

	// Decode of the arriving voxel: wraps, emission and interior test.
	always_comb begin
		in_bathy    = s_axis_tdata[SAMPLE_W +: BATHY_W];
		prev_plane  = plane_pos_q - PLANE_W'(1);
		wrap_f      = ((FW+1)'(fast_pos_q) + (FW+1)'(1)) >= nf;
		wrap_m      = wrap_f && (((MW+1)'(mid_pos_q) + (MW+1)'(1)) >= nm);
		wrap_p      = wrap_m && ((DEPTH_W'(plane_pos_q) + DEPTH_W'(1)) >= nd);
		in_emit     = (plane_pos_q != '0) && (DEPTH_W'(plane_pos_q) < nd);
		in_interior = (fast_pos_q != '0)
			&& (((FW+1)'(fast_pos_q) + (FW+1)'(1)) < nf)
			&& (mid_pos_q != '0)
			&& (((MW+1)'(mid_pos_q) + (MW+1)'(1)) < nm)
			&& (prev_plane != '0)
			&& (prev_plane > in_bathy);
	end

	assign in_accept = s_axis_tvalid && s_axis_tready;

	// Raster position counters advance on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_pos_q  <= '0;
			mid_pos_q   <= '0;
			plane_pos_q <= '0;
		end else if (in_accept) begin
			if (wrap_f) begin
				fast_pos_q <= '0;
				if (wrap_m) begin
					mid_pos_q   <= '0;
					plane_pos_q <= wrap_p ? '0 : plane_pos_q + PLANE_W'(1);
				end else begin
					mid_pos_q <= mid_pos_q + MW'(1);
				end
			end else begin
				fast_pos_q <= fast_pos_q + FW'(1);
			end
		end
	end

	// Voxel context held while it is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q     <= 1'b0;
			interior_q <= 1'b0;
			last_q     <= 1'b0;
		end else if (in_accept) begin
			emit_q     <= in_emit;
			interior_q <= in_emit && in_interior;
			last_q     <= wrap_p;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cur_q       <= $signed(s_axis_tdata[SAMPLE_W-1:0]);
			item_fast_q <= fast_pos_q;
			item_mid_q  <= mid_pos_q;
			item_bank_q <= plane_pos_q[0];
		end
	end

	// Sequencer state and read counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_cnt_q <= TAP_CENTER;
		end else begin
			state_q <= state_d;
			if (state_q == ST_READ) begin
				rd_cnt_q <= rd_cnt_q + tap_idx_t'(1);
			end else begin
				rd_cnt_q <= TAP_CENTER;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_d = (in_emit && in_interior) ? ST_READ : ST_FINISH;
				end
			end
			ST_READ: begin
				if (rd_cnt_q == TAP_VERT) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: state_d = ST_CALC;
			ST_CALC: begin
				if (calc_rsp.done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!emit_q || !out_vld_q || m_axis_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		ring_re       = (state_q == ST_READ);
		calc_start    = (state_q == ST_LOAD);
		ring_we       = (state_q == ST_FINISH);
		out_load      = (state_q == ST_FINISH) && emit_q && (!out_vld_q || m_axis_tready);
	end

	// Neighbor selection for each read slot; the vertical tap shares the
	// write-back address and is read before it is overwritten.
	always_comb begin
		rd_bank = !item_bank_q;
		rd_mid  = item_mid_q;
		rd_fast = item_fast_q;
		case (rd_cnt_q)
			TAP_CENTER:  ;
			TAP_FAST_LO: rd_fast = item_fast_q - FW'(1);
			TAP_FAST_HI: rd_fast = item_fast_q + FW'(1);
			TAP_MID_LO:  rd_mid  = item_mid_q - MW'(1);
			TAP_MID_HI:  rd_mid  = item_mid_q + MW'(1);
			TAP_VERT:    rd_bank = item_bank_q;
			default:     ;
		endcase
		ring_raddr = ring_addr(rd_bank, rd_mid, rd_fast);
		ring_waddr = ring_addr(item_bank_q, item_mid_q, item_fast_q);
	end

	// Ring memory with registered read data.
	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_q[ring_waddr] <= cur_q;
		end
		if (ring_re) begin
			ring_rdata_q <= ring_q[ring_raddr];
		end
	end

	// Read-return tracking and capture of the horizontal taps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= ring_re;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_cnt_q;
		if (rd_vld_s1 && (rd_idx_s1 != TAP_VERT)) begin
			tap_q[rd_idx_s1] <= $signed(ring_rdata_q);
		end
	end

	// The vertical tap goes to the pipeline straight from the read register.
	always_comb begin
		calc_req.start   = calc_start;
		calc_req.center  = tap_q[TAP_CENTER];
		calc_req.fast_lo = tap_q[TAP_FAST_LO];
		calc_req.fast_hi = tap_q[TAP_FAST_HI];
		calc_req.mid_lo  = tap_q[TAP_MID_LO];
		calc_req.mid_hi  = tap_q[TAP_MID_HI];
		calc_req.vert    = $signed(ring_rdata_q);
		calc_req.cur     = cur_q;
	end

	mals_calc u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (calc_req),
		.gain   (gain_q),
		.rsp    (calc_rsp)
	);

	// Output register decouples the result from the next voxel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_hv_q   <= interior_q ? calc_rsp.hv : '0;
			out_last_q <= last_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_hv_q;
	assign m_axis_tlast  = out_last_q;

	// Checks on the sequencing.
	`MALS_ASSERT_IMP(a_ring_rw_apart, clk, arst_n, ring_we, !ring_re, "ring read and write collide")
	`MALS_ASSERT_IMP(a_done_in_calc, clk, arst_n, calc_rsp.done, state_q == ST_CALC, "pipeline result outside calc state")
	`MALS_ASSERT_NXT(a_read_to_load, clk, arst_n, (state_q == ST_READ) && (rd_cnt_q == TAP_VERT), state_q == ST_LOAD, "read sequence overran")
	`MALS_ASSERT_NXT(a_finish_holds, clk, arst_n, (state_q == ST_FINISH) && emit_q && out_vld_q && !m_axis_tready, (state_q == ST_FINISH) && out_vld_q, "result dropped while output stalled")

endmodule

@@ tb/sv/increment_checker.sv @@
`timescale 1ns / 1ps
// Checker for the stencil: follows register writes and voxel beats, predicts and compares increments.
module increment_checker
	import mals_pkg::*;
#(
	parameter int MAX_FAST   = 128,
	parameter int MAX_MIDDLE = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_AW-1:0]     paddr,
	input  logic [APB_DW-1:0]     pwdata,
	input  logic [APB_DW-1:0]     prdata,
	input  logic                  pready,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_TDATA_W-1:0] s_axis_tdata,   // [23:0] sample, [35:24] bathy_depth
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [HV_W-1:0]       m_axis_tdata,   // [31:0] hv_increment
	input  logic                  m_axis_tlast,
	output int unsigned           fail_count,
	output int unsigned           outstanding,
	output int unsigned           checked_count,
	output int unsigned           volume_ends
);

	localparam int PLANE_WORDS = MAX_FAST * MAX_MIDDLE;
	localparam longint HV_HIGH = (64'sd1 <<< 31) - 1;
	localparam longint HV_LOW  = -(64'sd1 <<< 31);

	typedef struct {
		logic signed [HV_W-1:0] hv;
		logic                   is_last;
	} increment_t;

	// Two planes of past samples, indexed by plane parity, middle and fast position.
	logic signed [SAMPLE_W-1:0] sample_ring [2*PLANE_WORDS];
	increment_t                 increment_q [$];

	// Register copies, raw as written.
	logic [SIZE_W-1:0]  size_fast;
	logic [SIZE_W-1:0]  size_middle;
	logic [DEPTH_W-1:0] size_depth;
	logic [GAIN_W-1:0]  gain;

	int unsigned fast_pos;
	int unsigned middle_pos;
	int unsigned plane_pos;
	int unsigned fails;
	int unsigned checked;
	int unsigned ends_seen;

	function automatic int unsigned clamp_size(input int unsigned raw, input int unsigned hi);
		if (raw < MIN_SIZE)
			return MIN_SIZE;
		if (raw > hi)
			return hi;
		return raw;
	endfunction

	// Round to nearest on a 16-bit shift, ties toward plus infinity.
	function automatic longint round16(input longint v);
		return (v + 64'sd32768) >>> 16;
	endfunction

	function automatic longint ring_at(input int unsigned plane, input int unsigned mid,
		input int unsigned fast);
		longint v;
		v = sample_ring[(plane & 1) * PLANE_WORDS + mid * MAX_FAST + fast];
		return v;
	endfunction

	function automatic logic [APB_DW-1:0] reg_value(input logic [1:0] idx);
		case (idx)
			REG_SIZE_FAST:   return APB_DW'(size_fast);
			REG_SIZE_MIDDLE: return APB_DW'(size_middle);
			REG_SIZE_DEPTH:  return APB_DW'(size_depth);
			default:         return APB_DW'(gain);
		endcase
	endfunction

	// Takes one voxel: queues the increment of the voxel one plane back, if any,
	// then stores the sample and advances the raster position.
	function automatic void predict_increment(input logic signed [SAMPLE_W-1:0] cur_sample,
		input logic [BATHY_W-1:0] bathy);
		int unsigned nf, nm, nd, i1, i2, p, q;
		bit emit, wrap_f, wrap_m, wrap_p, interior;
		longint ctr, df, dm, dv, sum, s16, prod;
		increment_t inc;
		nf = clamp_size(size_fast, MAX_FAST);
		nm = clamp_size(size_middle, MAX_MIDDLE);
		nd = clamp_size(size_depth, MAX_DEPTH);
		i1 = fast_pos;
		i2 = middle_pos;
		p = plane_pos;
		emit = (p >= 1) && (p < nd);
		wrap_f = (i1 + 1 >= nf);
		wrap_m = wrap_f && (i2 + 1 >= nm);
		wrap_p = wrap_m && (p + 1 >= nd);
		if (emit) begin
			q = p - 1;
			interior = i1 >= 1 && i1 + 1 < nf && i2 >= 1 && i2 + 1 < nm && q >= 1 && q > bathy;
			inc.hv = '0;
			if (interior) begin
				ctr = ring_at(q, i2, i1);
				df = 2 * ctr - ring_at(q, i2, i1 - 1) - ring_at(q, i2, i1 + 1);
				dm = 2 * ctr - ring_at(q, i2 - 1, i1) - ring_at(q, i2 + 1, i1);
				dv = 2 * ctr - ring_at(q - 1, i2, i1) - longint'(cur_sample);
				sum = (df + dm) * 65536 + dv * CV_Q16;
				s16 = round16(sum);
				prod = round16(s16 * longint'(gain));
				if (prod > HV_HIGH)
					prod = HV_HIGH;
				else if (prod < HV_LOW)
					prod = HV_LOW;
				inc.hv = prod[HV_W-1:0];
			end
			inc.is_last = wrap_p;
			increment_q.push_back(inc);
		end

		sample_ring[(p & 1) * PLANE_WORDS + i2 * MAX_FAST + i1] = cur_sample;

		if (wrap_f) begin
			fast_pos = 0;
			if (wrap_m) begin
				middle_pos = 0;
				plane_pos = wrap_p ? 0 : p + 1;
			end else begin
				middle_pos = i2 + 1;
			end
		end else begin
			fast_pos = i1 + 1;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_fast = 8'd128;
			size_middle = 8'd128;
			size_depth = 13'd4096;
			gain = '0;
			fast_pos = 0;
			middle_pos = 0;
			plane_pos = 0;
			fails = 0;
			checked = 0;
			ends_seen = 0;
			increment_q.delete();
			fail_count <= 0;
			outstanding <= 0;
			checked_count <= 0;
			volume_ends <= 0;
		end else begin
			// Register writes update the copies; reads must return them.
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[3:2])
						REG_SIZE_FAST:   size_fast = pwdata[SIZE_W-1:0];
						REG_SIZE_MIDDLE: size_middle = pwdata[SIZE_W-1:0];
						REG_SIZE_DEPTH:  size_depth = pwdata[DEPTH_W-1:0];
						REG_GAIN:        gain = pwdata[GAIN_W-1:0];
						default: ;
					endcase
				end else if (prdata !== reg_value(paddr[3:2])) begin
					$error("prdata mismatch at register %0d: expected %0h, actual %0h",
						paddr[3:2], reg_value(paddr[3:2]), prdata);
					fails++;
				end
			end

			// An increment beat is matched against the oldest expectation.
			if (m_axis_tvalid && m_axis_tready) begin
				if (increment_q.size() == 0) begin
					$error("increment beat with nothing expected: hv_increment %0d, last %0b",
						$signed(m_axis_tdata), m_axis_tlast);
					fails++;
				end else begin
					increment_t exp_inc;
					exp_inc = increment_q.pop_front();
					checked++;
					if (m_axis_tlast === 1'b1)
						ends_seen++;
					if (m_axis_tdata !== exp_inc.hv) begin
						$error("hv_increment mismatch: expected %0d, actual %0d",
							exp_inc.hv, $signed(m_axis_tdata));
						fails++;
					end
					if (m_axis_tlast !== exp_inc.is_last) begin
						$error("last mismatch: expected %0b, actual %0b",
							exp_inc.is_last, m_axis_tlast);
						fails++;
					end
				end
			end

			// A voxel beat feeds the prediction.
			if (s_axis_tvalid && s_axis_tready)
				predict_increment(s_axis_tdata[SAMPLE_W-1:0],
					s_axis_tdata[SAMPLE_W+BATHY_W-1:SAMPLE_W]);

			fail_count <= fails;
			outstanding <= increment_q.size();
			checked_count <= checked;
			volume_ends <= ends_seen;
		end
	end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Top of the stencil testbench: clock, reset, register and voxel stimulus, and the verdict.
module testbench;
	import mals_pkg::*;

	localparam int MAX_FAST      = 128;
	localparam int MAX_MIDDLE    = 128;
	localparam int SETTLE_CYCLES = 32;
	localparam int HOLD_CYCLES   = 400;
	localparam longint CYCLE_LIMIT = 1000000;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 24'h7FFFFF;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 24'h800000;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_AW-1:0]     paddr;
	logic [APB_DW-1:0]     pwdata;
	logic [APB_DW-1:0]     prdata;
	logic                  pready;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata;   // [23:0] sample, [35:24] bathy_depth
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [HV_W-1:0]       m_axis_tdata;   // [31:0] hv_increment
	logic                  m_axis_tlast;

	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned checked_count;
	int unsigned volume_ends;

	// Raster position and sizes as the stimulus sees them.
	int unsigned cfg_fast;
	int unsigned cfg_middle;
	int unsigned cfg_depth;
	int unsigned pos_fast;
	int unsigned pos_middle;
	int unsigned pos_plane;
	int unsigned voxels_sent;
	int unsigned volumes_sent;
	bit          tx_quiet;
	bit          rx_quiet;
	bit          hold_req;
	longint      cycle_count;

	masked_anisotropic_laplacian_stencil #(
		.MAX_FAST   (MAX_FAST),
		.MAX_MIDDLE (MAX_MIDDLE)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	increment_checker #(
		.MAX_FAST   (MAX_FAST),
		.MAX_MIDDLE (MAX_MIDDLE)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.checked_count (checked_count),
		.volume_ends   (volume_ends)
	);

	// 8 ns clock.
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic int unsigned size_in_use(input int unsigned raw, input int unsigned hi);
		return raw < MIN_SIZE ? MIN_SIZE : (raw > hi ? hi : raw);
	endfunction

	// Idle lengths: mostly short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 2);
		if (r < 97)
			return $urandom_range(3, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_stall();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		if (r < 95)
			return $urandom_range(3, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int r;
		int near_zero;
		r = $urandom_range(0, 99);
		near_zero = $urandom_range(0, 600);
		if (r < 12)
			return SAMPLE_MAX;
		if (r < 24)
			return SAMPLE_MIN;
		if (r < 40)
			return SAMPLE_W'(near_zero - 300);
		return SAMPLE_W'($urandom());
	endfunction

	// Mostly shallow bathymetry so that interior voxels compute, some water columns.
	function automatic logic [BATHY_W-1:0] pick_bathy();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return '0;
		if (r < 70)
			return BATHY_W'(1);
		if (r < 85)
			return BATHY_W'($urandom_range(0, 6));
		if (r < 95)
			return BATHY_W'($urandom());
		return '1;
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			2: return GAIN_W'($urandom_range(0, 24'h1FFFF));
			default: return GAIN_W'($urandom());
		endcase
	endfunction

	// One APB transfer: setup cycle, then access cycle until pready.
	task automatic apb_access(input bit write, input logic [1:0] idx,
		input logic [APB_DW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (write) begin
			case (idx)
				REG_SIZE_FAST:   cfg_fast = 32'(value[SIZE_W-1:0]);
				REG_SIZE_MIDDLE: cfg_middle = 32'(value[SIZE_W-1:0]);
				REG_SIZE_DEPTH:  cfg_depth = 32'(value[DEPTH_W-1:0]);
				default: ;
			endcase
		end
	endtask

	task automatic read_back();
		apb_access(1'b0, REG_SIZE_FAST, '0);
		apb_access(1'b0, REG_SIZE_MIDDLE, '0);
		apb_access(1'b0, REG_SIZE_DEPTH, '0);
		apb_access(1'b0, REG_GAIN, '0);
	endtask

	task automatic configure(input int unsigned nf, input int unsigned nm, input int unsigned nd,
		input logic [GAIN_W-1:0] g);
		apb_access(1'b1, REG_SIZE_FAST, nf);
		apb_access(1'b1, REG_SIZE_MIDDLE, nm);
		apb_access(1'b1, REG_SIZE_DEPTH, nd);
		apb_access(1'b1, REG_GAIN, APB_DW'(g));
		read_back();
	endtask

	// Offers one voxel beat, holds it until accepted, then advances the raster position.
	task automatic feed_voxel(input logic [SAMPLE_W-1:0] smp, input logic [BATHY_W-1:0] bd);
		int gap;
		int unsigned nf, nm, nd;
		gap = tx_quiet ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_TDATA_W-SAMPLE_W-BATHY_W){1'b0}}, bd, smp};
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		voxels_sent++;
		nf = size_in_use(cfg_fast, MAX_FAST);
		nm = size_in_use(cfg_middle, MAX_MIDDLE);
		nd = size_in_use(cfg_depth, MAX_DEPTH);
		if (pos_fast + 1 >= nf) begin
			pos_fast = 0;
			if (pos_middle + 1 >= nm) begin
				pos_middle = 0;
				if (pos_plane + 1 >= nd) begin
					pos_plane = 0;
					volumes_sent++;
				end else begin
					pos_plane++;
				end
			end else begin
				pos_middle++;
			end
		end else begin
			pos_fast++;
		end
	endtask

	// Random voxels: a fixed count, or up to the end of the current volume.
	task automatic stream_voxels(input int unsigned count, input bit to_end);
		int unsigned start_vol;
		int unsigned n;
		start_vol = volumes_sent;
		n = 0;
		while (to_end ? (volumes_sent == start_vol) : (n < count)) begin
			feed_voxel(pick_sample(), pick_bathy());
			n++;
		end
	endtask

	// Stops offering voxels and waits until the block has delivered everything.
	task automatic settle_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Receiver: random stalls, quiet stretches, and one long hold-off on request.
	initial begin
		int stall_left;
		stall_left = 0;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else if (!rx_quiet && $urandom_range(0, 99) < 20) begin
				m_axis_tready <= 1'b0;
				stall_left = pick_stall() - 1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Run limit.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Cycle limit reached with %0d increments still due.", outstanding);
		$display("[masked_anisotropic_laplacian_stencil] ERROR");
		$finish;
	end

	// Stimulus and verdict.
	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_fast = 128;
		cfg_middle = 128;
		cfg_depth = 4096;
		pos_fast = 0;
		pos_middle = 0;
		pos_plane = 0;
		voxels_sent = 0;
		volumes_sent = 0;
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		hold_req = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values of the registers.
		read_back();

		// Smallest volume through clamped sizes at full gain: the one interior voxel
		// sits at the positive peak among negative peaks, so the increment saturates.
		configure(0, 1, 2, '1);
		for (int k = 0; k < 27; k++)
			feed_voxel(k == 13 ? SAMPLE_MAX : SAMPLE_MIN,
				(k == 4 || k == 13 || k == 22) ? BATHY_W'(0) : BATHY_W'(12'hFFF));
		settle_idle();

		// Small random volumes with assorted gains and idling.
		for (int v = 0; v < 3; v++) begin
			configure($urandom_range(3, 6), $urandom_range(3, 5), $urandom_range(3, 4),
				pick_gain());
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			stream_voxels(0, 1'b1);
			settle_idle();
		end

		// The receiver holds off for a long stretch while voxels keep coming.
		configure(6, 5, 4, pick_gain());
		tx_quiet = 1'b1;
		rx_quiet = 1'b0;
		stream_voxels(40, 1'b0);
		hold_req = 1'b1;
		stream_voxels(0, 1'b1);
		settle_idle();
		tx_quiet = 1'b0;

		// All sizes clamped from above, then shrunk in the second row of plane zero.
		configure(255, 255, 8191, pick_gain());
		stream_voxels(130, 1'b0);
		settle_idle();
		apb_access(1'b1, REG_SIZE_FAST, 4);
		apb_access(1'b1, REG_SIZE_MIDDLE, 3);
		apb_access(1'b1, REG_SIZE_DEPTH, 3);
		apb_access(1'b1, REG_GAIN, APB_DW'(pick_gain()));
		read_back();
		stream_voxels(0, 1'b1);
		settle_idle();

		// Depth cut below the current plane: the rest of that plane emits nothing.
		configure(5, 4, 8191, pick_gain());
		stream_voxels(67, 1'b0);
		settle_idle();
		apb_access(1'b1, REG_SIZE_FAST, 4);
		apb_access(1'b1, REG_SIZE_DEPTH, 0);
		apb_access(1'b1, REG_GAIN, '1);
		read_back();
		stream_voxels(0, 1'b1);
		settle_idle();

		// One more random volume.
		configure($urandom_range(3, 7), $urandom_range(3, 6), $urandom_range(3, 5),
			pick_gain());
		tx_quiet = ($urandom_range(0, 3) == 0);
		rx_quiet = ($urandom_range(0, 3) == 0);
		stream_voxels(0, 1'b1);
		settle_idle();

		$display("Sent %0d voxels in %0d volumes; %0d increment beats checked, %0d volume ends.",
			voxels_sent, volumes_sent, checked_count, volume_ends);
		$display("Sizes from the clamped minimum to the clamped maximum, gains 0 to %s",
			"full scale, mid-volume size cuts and a long output hold-off.");
		if (fail_count == 0 && outstanding == 0)
			$display("[masked_anisotropic_laplacian_stencil] OK");
		else
			$display("[masked_anisotropic_laplacian_stencil] ERROR");
		$finish;
	end

endmodule
